// ----- design/lac_pkg.sv -----
// Shared types, codes and defaults for the LRU associative cache.
`timescale 1ns / 1ps
`default_nettype none
package lac_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_IN_W   = 32;
    localparam int VALUE_IN_W = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_W      = 5;
    localparam int OCC_OUT_W  = 5;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_GET      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUT      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TOUCH,
        OP_FILL_FREE,
        OP_FILL_FULL,
        OP_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     active;
        logic     sel;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic match;
        logic pick;
    } t_cell_sts;

endpackage
`default_nettype wire

// ----- design/lru_assoc_cache.sv -----
// Top level: fully associative LRU cache built from a row of slot cells.
// The item is held in the input register, and the result is registered in the output register.
// Throughput: one item per cycle while the result side keeps up and no removal sweep runs; the key
//   compare and rank update in all cells work on the item held in the input register.
// Writing active_slots starts a removal sweep over the SLOTS cells (one cell per cycle), no item taken.
// Reset (synchronous, active low): all slots empty, occupancy 0, active_slots = SLOTS.
`timescale 1ns / 1ps
`default_nettype none
module lru_assoc_cache #(
    parameter int SLOTS      = lac_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lac_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lac_pkg::VALUE_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [lac_pkg::CFG_W-1:0]       i_cfg_data,      // active_slots
    input  wire                            i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire [lac_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // key[31:0], value[63:32]
    input  wire [lac_pkg::MODE_W-1:0]      i_s_axis_tuser,  // mode[1:0]
    output logic                           o_m_axis_tvalid,
    input  wire                            i_m_axis_tready,
    output logic [lac_pkg::OUT_DATA_W-1:0] o_m_axis_tdata   // hit[0], read_value[32:1],
                                                            // evicted[33], occupancy[38:34]
);
    import lac_pkg::*;

    localparam int KEY_W = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int VAL_W = (VALUE_BITS < VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;
    localparam int AGE_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic                 r_have;
    logic [MODE_W-1:0]    r_mode;
    logic [KEY_W-1:0]     r_key;
    logic [VAL_W-1:0]     r_val;
    logic [CNT_W-1:0]     r_act;
    logic [CNT_W-1:0]     r_occ;
    logic                 r_sweep;
    logic [AGE_W-1:0]     r_ptr;
    logic                 r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [CNT_W-1:0]     n_act;
    logic [CNT_W-1:0]     n_occ;
    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     occ_ext;

    logic                 adv;
    logic                 s_take;
    t_cell_op             op;
    logic [AGE_W-1:0]     ref_age;
    logic                 hit_any;
    logic                 pick_any;
    logic [AGE_W-1:0]     hit_age;
    logic [AGE_W-1:0]     pick_age;
    logic [VAL_W-1:0]     hit_value;
    logic                 res_hit;
    logic [VALUE_IN_W-1:0] res_value;
    logic                 res_evict;

    t_cell_ctl            cell_ctl   [SLOTS];
    t_cell_sts            cell_sts   [SLOTS];
    logic [AGE_W-1:0]     cell_age   [SLOTS];
    logic [VAL_W-1:0]     cell_value [SLOTS];
    logic [SLOTS:0]       free_seen;
    logic [SLOTS-1:0]     valid_vec;

    assign adv             = r_have && !r_sweep && (!r_ovalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_sweep && (!r_have || adv);
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign free_seen[0]    = 1'b0;

    always_comb begin
        hit_any   = 1'b0;
        pick_any  = 1'b0;
        hit_age   = '0;
        pick_age  = '0;
        hit_value = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_any  = hit_any  | cell_sts[i].match;
            pick_any = pick_any | cell_sts[i].pick;
            hit_age  = hit_age  | (cell_sts[i].match ? cell_age[i] : '0);
            pick_age = pick_age | (cell_sts[i].pick ? cell_age[i] : '0);
            hit_value = hit_value | (cell_sts[i].match ? cell_value[i] : '0);
            valid_vec[i] = cell_sts[i].valid;
        end
    end

    always_comb begin
        op      = OP_NONE;
        ref_age = '0;
        if (r_sweep) begin
            if (pick_any) begin
                op      = OP_REMOVE;
                ref_age = pick_age;
            end
        end else if (adv) begin
            unique case (r_mode)
                MODE_CLEAR: begin
                    op = OP_CLEAR;
                end
                MODE_GET: begin
                    if (hit_any) begin
                        op      = OP_TOUCH;
                        ref_age = hit_age;
                    end
                end
                MODE_CONTAINS: begin
                    op = OP_NONE;
                end
                MODE_PUT: begin
                    if (hit_any) begin
                        op      = OP_TOUCH;
                        ref_age = hit_age;
                    end else if (free_seen[SLOTS]) begin
                        op = OP_FILL_FREE;
                    end else begin
                        op      = OP_FILL_FULL;
                        ref_age = AGE_W'(r_occ - 1'b1);
                    end
                end
                default: begin
                    op = OP_NONE;
                end
            endcase
        end
    end

    always_comb begin
        n_occ = r_occ;
        unique case (op)
            OP_FILL_FREE: n_occ = r_occ + 1'b1;
            OP_REMOVE:    n_occ = r_occ - 1'b1;
            OP_CLEAR:     n_occ = '0;
            default:      n_occ = r_occ;
        endcase
        occ_ext   = CMP_W'(n_occ);
        res_hit   = (r_mode != MODE_CLEAR) && hit_any;
        res_value = ((r_mode == MODE_GET) && hit_any) ? VALUE_IN_W'(hit_value) : '0;
        res_evict = (op == OP_FILL_FULL);
    end

    always_comb begin
        cfg_ext = CMP_W'(i_cfg_data);
        if (cfg_ext == '0) begin
            n_act = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(SLOTS)) begin
            n_act = CNT_W'(SLOTS);
        end else begin
            n_act = CNT_W'(cfg_ext);
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        always_comb begin
            cell_ctl[g].op     = op;
            cell_ctl[g].active = CNT_W'(g) < r_act;
            cell_ctl[g].sel    = r_sweep && (r_ptr == AGE_W'(g)) && (CNT_W'(g) >= r_act);
        end

        lac_cell #(
            .KEY_W (KEY_W),
            .VAL_W (VAL_W),
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl[g]),
            .i_key       (r_key),
            .i_value     (r_val),
            .i_ref_age   (ref_age),
            .i_free_seen (free_seen[g]),
            .o_free_seen (free_seen[g+1]),
            .o_sts       (cell_sts[g]),
            .o_age       (cell_age[g]),
            .o_value     (cell_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_act    <= CNT_W'(SLOTS);
            r_occ    <= '0;
            r_sweep  <= 1'b0;
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (s_take) begin
                r_have <= 1'b1;
            end else if (adv) begin
                r_have <= 1'b0;
            end

            r_occ <= n_occ;

            if (i_cfg_we) begin
                r_act   <= n_act;
                r_sweep <= 1'b1;
                r_ptr   <= '0;
            end else if (r_sweep) begin
                if (r_ptr == AGE_W'(SLOTS - 1)) begin
                    r_sweep <= 1'b0;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end

            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_mode <= i_s_axis_tuser;
            r_key  <= i_s_axis_tdata[KEY_W-1:0];
            r_val  <= i_s_axis_tdata[KEY_IN_W +: VAL_W];
        end
        if (adv) begin
            r_odata <= {1'b0, occ_ext[OCC_OUT_W-1:0], res_evict, res_value, res_hit};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_occ))
        else $error("occupancy count differs from valid slots");

    a_occ_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sweep |-> (r_occ <= r_act))
        else $error("occupancy above active slot limit");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_FILL_FULL) |-> (!hit_any && (r_occ == r_act)))
        else $error("eviction without a full miss");

    a_no_item_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |=> !$past(s_take))
        else $error("item taken during removal sweep");

endmodule
`default_nettype wire

// ----- design/lac_cell.sv -----
// One cache slot: valid bit, key, value and recency rank, plus the free-slot chain link.
`timescale 1ns / 1ps
`default_nettype none
module lac_cell #(
    parameter int KEY_W = 32,
    parameter int VAL_W = 32,
    parameter int AGE_W = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire lac_pkg::t_cell_ctl i_ctl,
    input  wire [KEY_W-1:0]      i_key,
    input  wire [VAL_W-1:0]      i_value,
    input  wire [AGE_W-1:0]      i_ref_age,
    input  wire                  i_free_seen,
    output logic                 o_free_seen,
    output lac_pkg::t_cell_sts   o_sts,
    output logic [AGE_W-1:0]     o_age,
    output logic [VAL_W-1:0]     o_value
);
    import lac_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [AGE_W-1:0] r_age;

    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [VAL_W-1:0] n_value;
    logic [AGE_W-1:0] n_age;

    logic match;
    logic free_here;

    assign match       = r_valid && (r_key == i_key);
    assign free_here   = !r_valid && i_ctl.active;
    assign o_free_seen = i_free_seen || free_here;

    assign o_sts.valid = r_valid;
    assign o_sts.match = match;
    assign o_sts.pick  = i_ctl.sel && r_valid;
    assign o_age       = r_age;
    assign o_value     = r_value;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        n_age   = r_age;
        unique case (i_ctl.op)
            OP_NONE: begin
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_TOUCH: begin
                if (match) begin
                    n_age = '0;
                end else if (r_valid && (r_age < i_ref_age)) begin
                    n_age = r_age + 1'b1;
                end
            end
            OP_FILL_FREE: begin
                if (free_here && !i_free_seen) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_value = i_value;
                    n_age   = '0;
                end else if (r_valid) begin
                    n_age = r_age + 1'b1;
                end
            end
            OP_FILL_FULL: begin
                if (r_valid && (r_age == i_ref_age)) begin
                    n_key   = i_key;
                    n_value = i_value;
                    n_age   = '0;
                end else if (r_valid) begin
                    n_age = r_age + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (i_ctl.sel && r_valid) begin
                    n_valid = 1'b0;
                end else if (r_valid && (r_age > i_ref_age)) begin
                    n_age = r_age - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule
`default_nettype wire

// ----- tb/sv/lac_checker.sv -----
// Checker for the LRU associative cache: predicts each reply and compares it with the result channel.
`timescale 1ns / 1ps
module lac_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [lac_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire                            i_s_tvalid,
    input  wire                            i_s_tready,
    input  wire [lac_pkg::IN_DATA_W-1:0]   i_s_tdata,   // key[31:0], value[63:32]
    input  wire [lac_pkg::MODE_W-1:0]      i_s_tuser,   // mode[1:0]
    input  wire                            i_m_tvalid,
    input  wire                            i_m_tready,
    input  wire [lac_pkg::OUT_DATA_W-1:0]  i_m_tdata,   // hit[0], read_value[32:1],
                                                        // evicted[33], occupancy[38:34]
    output int                             o_fail_count,
    output int                             o_pending
);
    import lac_pkg::*;

    localparam int NSLOTS = SLOTS_DEF;

    typedef struct packed {
        logic [OCC_OUT_W-1:0]  occupancy;
        logic                  evicted;
        logic [VALUE_IN_W-1:0] read_value;
        logic                  hit;
    } t_reply;

    logic                  slot_used [NSLOTS];
    logic [KEY_IN_W-1:0]   slot_tag  [NSLOTS];
    logic [VALUE_IN_W-1:0] slot_data [NSLOTS];
    logic [63:0]           slot_age  [NSLOTS];
    logic [63:0]           access_count;
    int                    slot_limit;
    t_reply                replies_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_reply cache_access(logic [MODE_W-1:0] mode, logic [KEY_IN_W-1:0] key,
                                            logic [VALUE_IN_W-1:0] value);
        t_reply r;
        int     i;
        int     found;
        int     target;
        r = '0;
        if (mode == MODE_CLEAR) begin
            for (i = 0; i < NSLOTS; i++) slot_used[i] = 1'b0;
        end else begin
            found = -1;
            for (i = 0; i < slot_limit; i++)
                if (found < 0 && slot_used[i] && slot_tag[i] == key) found = i;
            if (found >= 0) begin
                r.hit = 1'b1;
                if (mode != MODE_CONTAINS) begin
                    access_count     = access_count + 64'd1;
                    slot_age[found]  = access_count;
                    if (mode == MODE_GET) r.read_value = slot_data[found];
                end
            end else if (mode == MODE_PUT) begin
                target = -1;
                for (i = 0; i < slot_limit; i++)
                    if (target < 0 && !slot_used[i]) target = i;
                if (target < 0) begin
                    for (i = 0; i < slot_limit; i++)
                        if (slot_used[i] && (target < 0 || slot_age[i] < slot_age[target]))
                            target = i;
                    r.evicted = (target >= 0);
                end
                if (target >= 0) begin
                    access_count      = access_count + 64'd1;
                    slot_used[target] = 1'b1;
                    slot_tag[target]  = key;
                    slot_data[target] = value;
                    slot_age[target]  = access_count;
                end
            end
        end
        for (i = 0; i < NSLOTS; i++) r.occupancy += slot_used[i];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        int     lim;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOTS; i++) slot_used[i] = 1'b0;
            access_count = '0;
            slot_limit   = NSLOTS;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                lim = i_cfg_data;
                if (lim < 1) lim = 1;
                if (lim > NSLOTS) lim = NSLOTS;
                for (int i = lim; i < NSLOTS; i++) slot_used[i] = 1'b0;
                slot_limit = lim;
            end
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(cache_access(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]));
            if (i_m_tvalid && i_m_tready) begin
                got = t_reply'(i_m_tdata[38:0]);
                if (replies_due.size() == 0) begin
                    $display("%0t: item expected none got 0x%0h", $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
                        o_fail_count++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value expected 0x%08h got 0x%08h", $time,
                                 want.read_value, got.read_value);
                        o_fail_count++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $display("%0t: evicted expected %0d got %0d", $time, want.evicted,
                                 got.evicted);
                        o_fail_count++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                                 got.occupancy);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the LRU associative cache bench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module testbench;
    import lac_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;

    logic                  i_clk      = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_W-1:0]      cfg_data   = '0;
    logic                  s_tvalid   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic [MODE_W-1:0]     s_tuser    = '0;
    logic                  m_tready   = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    int                    fail_count;
    int                    pending;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    logic                  hold_off_req = 1'b0;
    logic                  hold_taken   = 1'b0;
    int                    quiet_cycles = 0;
    logic [KEY_IN_W-1:0]   key_pool [24];

    lru_assoc_cache u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    lac_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_IN_W-1:0] key,
                             logic [VALUE_IN_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= mode;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] limit);
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int unsigned         phase_cfg [10] = '{2, 16, 1, 0, 4, 31, 17, 8, 8, 16};
        int unsigned         phase_len [10] = '{90, 150, 100, 60, 130, 140, 100, 140, 80, 100};
        int                  span;
        int                  roll;
        logic [MODE_W-1:0]   mode;
        logic [KEY_IN_W-1:0] key;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < 24; k++) key_pool[k] = $urandom;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 10; p++) begin
            tx_idle_pct <= (p < 4) ? 26 : (p < 7) ? 45 : 0;
            rx_idle_pct <= (p < 4) ? 45 : (p < 7) ? 26 : 0;
            wait_drain();
            write_limit(phase_cfg[p]);
            if (p == 5) hold_off_req <= 1'b1;
            span = (phase_cfg[p] == 0) ? 1 : (phase_cfg[p] > 16) ? 16 : phase_cfg[p];
            span = (2 * span + 1 > 23) ? 23 : 2 * span + 1;
            if (p == 0) begin
                send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
                send_item(MODE_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                send_item(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
                send_item(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
                send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
                send_item(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
                send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
                send_item(MODE_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000);
                send_item(MODE_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
                send_item(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
                send_item(MODE_CONTAINS, 32'hA5A5_A5A5, 32'h0000_0000);
                send_item(MODE_GET, 32'h0000_0000, 32'hDEAD_BEEF);
                send_item(MODE_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
                send_item(MODE_GET, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
                send_item(MODE_CLEAR, $urandom, $urandom);
                send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
                send_item(MODE_PUT, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
                send_item(MODE_CONTAINS, 32'h5A5A_5A5A, 32'h0000_0000);
                send_item(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                send_item(MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
                send_item(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end
            for (int n = 0; n < phase_len[p]; n++) begin
                roll = $urandom_range(0, 99);
                mode = (roll < 42) ? MODE_PUT : (roll < 72) ? MODE_GET :
                       (roll < 97) ? MODE_CONTAINS : MODE_CLEAR;
                if ($urandom_range(0, 9) == 0) key = $urandom;
                else key = key_pool[$urandom_range(0, span)];
                send_item(mode, key, $urandom);
            end
        end
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
